[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

[hw/rtl/pmic_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pmic_pkg;

  localparam int unsigned LevelSteps = 12;
  localparam int unsigned TableLen   = 12;
  localparam int unsigned ScanLen    = (LevelSteps < TableLen) ? LevelSteps : TableLen;

  localparam int unsigned MvW  = 13;
  localparam int unsigned PctW = 7;
  localparam int unsigned SecW = 16;
  localparam int unsigned MsW  = 27;

  typedef enum logic [2:0] {
    OP_INIT     = 3'd0,
    OP_BATTERY  = 3'd1,
    OP_ACTIVITY = 3'd2,
    OP_CHECK    = 3'd3,
    OP_SET_MODE = 3'd4,
    OP_WAKE     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    MODE_PERF     = 2'd0,
    MODE_BALANCED = 2'd1,
    MODE_SAVE     = 2'd2,
    MODE_MAX_SAVE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    SLEEP_NONE  = 2'd0,
    SLEEP_LIGHT = 2'd1,
    SLEEP_DEEP  = 2'd2
  } sleep_e;

  typedef enum logic [1:0] {
    REG_LIGHT_TIMEOUT = 2'd0,
    REG_DEEP_TIMEOUT  = 2'd1,
    REG_LOW_MV        = 2'd2,
    REG_CRITICAL_MV   = 2'd3
  } reg_e;

  localparam logic [MvW-1:0] LevelMv [TableLen] = '{
    13'd4200, 13'd4100, 13'd4000, 13'd3900, 13'd3800, 13'd3700,
    13'd3600, 13'd3500, 13'd3400, 13'd3300, 13'd3200, 13'd3100
  };

  localparam logic [PctW-1:0] LevelPct [TableLen] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
    7'd40,  7'd30, 7'd20, 7'd10, 7'd5,  7'd0
  };

  function automatic logic [7:0] max_freq_of(mode_e m);
    case (m)
      MODE_PERF:     return 8'd240;
      MODE_BALANCED: return 8'd160;
      MODE_SAVE:     return 8'd80;
      default:       return 8'd40;
    endcase
  endfunction

  function automatic logic [7:0] min_freq_of(mode_e m);
    case (m)
      MODE_PERF:     return 8'd240;
      MODE_BALANCED: return 8'd80;
      default:       return 8'd40;
    endcase
  endfunction

  function automatic logic [4:0] mask_of(mode_e m);
    case (m)
      MODE_PERF:     return 5'd31;
      MODE_BALANCED: return 5'd15;
      MODE_SAVE:     return 5'd11;
      default:       return 5'd1;
    endcase
  endfunction

  function automatic logic [MsW-1:0] scale_ms(logic [SecW-1:0] secs, mode_e m);
    logic [SecW:0] s;
    case (m)
      MODE_PERF:     s = {secs, 1'b0};
      MODE_BALANCED: s = {1'b0, secs};
      MODE_SAVE:     s = {2'b00, secs[SecW-1:1]};
      default:       s = {3'b000, secs[SecW-1:2]};
    endcase
    return MsW'(s) * MsW'(1000);
  endfunction

  function automatic logic [PctW-1:0] percent_of(logic [MvW-1:0] mv);
    logic [PctW-1:0] pct;
    pct = '0;
    for (int i = ScanLen - 1; i >= 0; i--) begin
      if (mv >= LevelMv[i]) begin
        pct = LevelPct[i];
      end
    end
    return pct;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/power_mode_and_inactivity_controller.sv]
`timescale 1ns / 1ps
`default_nettype none

// Requests go through an input register, results through a result register.
// Throughput: one request per cycle; the input stalls only while the result
// register holds an untaken result and the input register is full.
// Reset: asynchronous, active low; balanced mode, all peripherals enabled,
// battery status cleared, timeouts 30 s and 300 s, thresholds 3400/3300 mV.
module power_mode_and_inactivity_controller import pmic_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [SecW-1:0]   cfg_wdata_i,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic [2:0]        op_i,
  input  wire logic [11:0]       pin_mv_i,
  input  wire logic [31:0]       now_ms_i,
  input  wire logic [1:0]        requested_mode_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [1:0]        mode_o,
  output      logic [7:0]        ceiling_mhz_o,
  output      logic [7:0]        floor_mhz_o,
  output      logic              auto_light_sleep_o,
  output      logic [4:0]        peripheral_enables_o,
  output      logic [MvW-1:0]    battery_mv_out_o,
  output      logic [PctW-1:0]   battery_percent_o,
  output      logic              battery_is_low_o,
  output      logic              battery_is_critical_o,
  output      logic [1:0]        sleep_action_o,
  output      logic [31:0]       light_sleep_ms_o,
  output      logic              asleep_o
);

  logic [SecW-1:0] light_sec_q, deep_sec_q;
  logic [MvW-1:0]  low_mv_q, crit_mv_q;

  logic            in_valid_q;
  logic [2:0]      op_q;
  logic [11:0]     pin_q;
  logic [31:0]     now_q;
  logic [1:0]      req_q;

  mode_e           mode_q, mode_d;
  logic [4:0]      mask_q, mask_d;
  logic [31:0]     last_q, last_d;
  logic            sleeping_q, sleeping_d;
  logic [MvW-1:0]  bat_mv_q, bat_mv_d;
  logic [PctW-1:0] pct_q, pct_d;
  logic            low_q, low_d;
  logic            crit_q, crit_d;

  logic            out_valid_q;
  logic [1:0]      action_q;
  logic [31:0]     duration_q;
  sleep_e          action_d;
  logic [31:0]     duration_d;

  logic            advance;
  logic [MvW-1:0]  samp_mv;
  logic            samp_low, samp_crit;
  logic [31:0]     idle_ms, deep_ms, light_ms;
  mode_e           target;
  logic            change;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_sec_q <= SecW'(30);
      deep_sec_q  <= SecW'(300);
      low_mv_q    <= MvW'(3400);
      crit_mv_q   <= MvW'(3300);
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_LIGHT_TIMEOUT: light_sec_q <= cfg_wdata_i;
        REG_DEEP_TIMEOUT:  deep_sec_q  <= cfg_wdata_i;
        REG_LOW_MV:        low_mv_q    <= cfg_wdata_i[MvW-1:0];
        REG_CRITICAL_MV:   crit_mv_q   <= cfg_wdata_i[MvW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      op_q  <= op_i;
      pin_q <= pin_mv_i;
      now_q <= now_ms_i;
      req_q <= requested_mode_i;
    end
  end

  assign samp_mv   = {pin_q, 1'b0};
  assign samp_low  = samp_mv <= low_mv_q;
  assign samp_crit = samp_mv <= crit_mv_q;
  assign idle_ms   = now_q - last_q;
  assign deep_ms   = 32'(scale_ms(deep_sec_q, mode_q));
  assign light_ms  = 32'(scale_ms(light_sec_q, mode_q));

  always_comb begin
    mode_d     = mode_q;
    mask_d     = mask_q;
    last_d     = last_q;
    sleeping_d = sleeping_q;
    bat_mv_d   = bat_mv_q;
    pct_d      = pct_q;
    low_d      = low_q;
    crit_d     = crit_q;
    action_d   = SLEEP_NONE;
    duration_d = '0;
    target     = mode_q;
    change     = 1'b0;
    case (op_e'(op_q))
      OP_INIT: begin
        bat_mv_d = samp_mv;
        pct_d    = percent_of(samp_mv);
        low_d    = samp_low;
        crit_d   = samp_crit;
        target   = samp_crit ? MODE_MAX_SAVE : (samp_low ? MODE_SAVE : MODE_BALANCED);
        change   = 1'b1;
        last_d   = now_q;
      end
      OP_BATTERY: begin
        bat_mv_d = samp_mv;
        pct_d    = percent_of(samp_mv);
        low_d    = samp_low;
        crit_d   = samp_crit;
      end
      OP_ACTIVITY: begin
        last_d = now_q;
      end
      OP_CHECK: begin
        if (!sleeping_q) begin
          if (idle_ms > deep_ms) begin
            action_d = SLEEP_DEEP;
          end else if (idle_ms > light_ms) begin
            action_d   = SLEEP_LIGHT;
            duration_d = deep_ms - idle_ms;
            sleeping_d = 1'b1;
          end
        end
      end
      OP_SET_MODE: begin
        target = mode_e'(req_q);
        change = 1'b1;
      end
      OP_WAKE: begin
        sleeping_d = 1'b0;
        last_d     = now_q;
        target     = MODE_BALANCED;
        change     = (mode_q == MODE_MAX_SAVE);
      end
      default: ;
    endcase
    if (change && target != mode_q) begin
      mode_d = target;
      mask_d = mask_of(target);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_BALANCED;
      mask_q      <= 5'd31;
      last_q      <= '0;
      sleeping_q  <= 1'b0;
      bat_mv_q    <= '0;
      pct_q       <= '0;
      low_q       <= 1'b0;
      crit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        mode_q     <= mode_d;
        mask_q     <= mask_d;
        last_q     <= last_d;
        sleeping_q <= sleeping_d;
        bat_mv_q   <= bat_mv_d;
        pct_q      <= pct_d;
        low_q      <= low_d;
        crit_q     <= crit_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mode_o                <= mode_d;
      ceiling_mhz_o         <= max_freq_of(mode_d);
      floor_mhz_o           <= min_freq_of(mode_d);
      auto_light_sleep_o    <= (mode_d != MODE_PERF);
      peripheral_enables_o  <= mask_d;
      battery_mv_out_o      <= bat_mv_d;
      battery_percent_o     <= pct_d;
      battery_is_low_o      <= low_d;
      battery_is_critical_o <= crit_d;
      action_q              <= action_d;
      duration_q            <= duration_d;
      asleep_o              <= sleeping_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sleep_action_o   = action_q;
  assign light_sleep_ms_o = duration_q;

endmodule

`default_nettype wire

[hw/rtl/pmic_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pmic_checker import pmic_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  mode_o,
  input wire logic        auto_light_sleep_o,
  input wire logic [1:0]  sleep_action_o,
  input wire logic [31:0] light_sleep_ms_o,
  input wire logic        asleep_o
);

  `ASSERT_ALWAYS(a_reset_clears_valid, clk_i, !rst_ni |=> !out_valid_o)

  `ASSERT_CLK(a_stalled_result_holds, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(light_sleep_ms_o))

  `ASSERT_CLK(a_light_sleep_sets_flag, clk_i, rst_ni,
    out_valid_o && sleep_action_o == SLEEP_LIGHT |-> asleep_o)

  `ASSERT_CLK(a_duration_only_light, clk_i, rst_ni,
    out_valid_o && sleep_action_o != SLEEP_LIGHT |-> light_sleep_ms_o == 32'd0)

  `ASSERT_CLK(a_auto_sleep_by_mode, clk_i, rst_ni,
    out_valid_o |-> auto_light_sleep_o == (mode_o != MODE_PERF))

endmodule

bind power_mode_and_inactivity_controller pmic_checker u_pmic_checker (.*);

`default_nettype wire
